// ===== hw/rtl/pdu_pkg.sv =====
package pdu_pkg;

    localparam int POS_W      = 24;
    localparam int D_W        = POS_W + 1;
    localparam int COEF_W     = 21;
    localparam int CFG_W      = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int WRAP_W     = 3;
    localparam int CU_W       = 26;
    localparam int U_W        = 41;
    localparam int MAG_W      = 23;
    localparam int ROOT_W     = 24;
    localparam int SQ_W       = 48;
    localparam int MAX_SHIFTS_DEF = 2;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [D_W-1:0]    d_t;
    typedef logic signed [CU_W-1:0]   cu_t;
    typedef logic signed [U_W-1:0]    u_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_A  = 3'd0,
        CFG_CELL_B  = 3'd1,
        CFG_CELL_C  = 3'd2,
        CFG_INV_X   = 3'd3,
        CFG_INV_Y   = 3'd4,
        CFG_INV_Z   = 3'd5,
        CFG_WRAP    = 3'd6,
        CFG_REDUCED = 3'd7
    } cfg_reg_t;

endpackage

// ===== hw/rtl/pdu_reduced.sv =====
module pdu_reduced (
    input  logic          clk,
    input  pdu_pkg::d_t    d   [3],
    input  pdu_pkg::coef_t inv [3][3],
    input  pdu_pkg::coef_t col [3][3],
    input  logic [pdu_pkg::WRAP_W-1:0] wrap,
    output pdu_pkg::u_t    u   [3]
);

    localparam int P1_W  = pdu_pkg::COEF_W + pdu_pkg::D_W;
    localparam int ACC_W = P1_W + 2;
    localparam int S_W   = ACC_W + 1 - 10;
    localparam int LO_W  = 19;
    localparam int HI_W  = S_W - LO_W;
    localparam int PL_W  = pdu_pkg::COEF_W + LO_W + 1;
    localparam int PH_W  = pdu_pkg::COEF_W + HI_W;
    localparam int SL_W  = PL_W + 2;
    localparam int SH_W  = PH_W + 2;
    localparam int T_W   = SH_W + LO_W + 1;

    logic signed [P1_W-1:0] p1_reg [3][3];
    logic signed [S_W-1:0]  s_reg  [3];
    logic signed [PL_W-1:0] pl_reg [3][3];
    logic signed [PH_W-1:0] ph_reg [3][3];
    pdu_pkg::u_t            u_reg  [3];

    logic signed [ACC_W-1:0] acc  [3];
    logic signed [ACC_W-1:0] accw [3];
    logic signed [ACC_W:0]   sr   [3];
    logic signed [SL_W-1:0]  sl   [3];
    logic signed [SH_W-1:0]  sh   [3];
    logic signed [T_W-1:0]   tot  [3];

    // inverse products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p1_reg[i][j] <= inv[i][j] * d[j];
            end
        end
    end

    // reduced coordinate, nearest-integer wrap, round to Q.19
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ACC_W'(p1_reg[i][0]) + ACC_W'(p1_reg[i][1]) + ACC_W'(p1_reg[i][2]);
            accw[i] = wrap[i] ? ACC_W'($signed(acc[i][28:0])) : acc[i];
            sr[i] = (ACC_W+1)'(accw[i]) + (ACC_W+1)'(512);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_reg[i] <= sr[i][10 +: S_W];
        end
    end

    // cell products, split over low and high halves of s
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pl_reg[i][k] <= col[k][i] * $signed({1'b0, s_reg[k][LO_W-1:0]});
                ph_reg[i][k] <= col[k][i] * $signed(s_reg[k][S_W-1:LO_W]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sl[i] = SL_W'(pl_reg[i][0]) + SL_W'(pl_reg[i][1]) + SL_W'(pl_reg[i][2]);
            sh[i] = SH_W'(ph_reg[i][0]) + SH_W'(ph_reg[i][1]) + SH_W'(ph_reg[i][2]);
            tot[i] = (T_W'(sh[i]) <<< LO_W) + T_W'(sl[i]) + (T_W'(1) <<< 18);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_reg[i] <= tot[i][19 +: pdu_pkg::U_W];
        end
    end

    assign u = u_reg;

endmodule

// ===== hw/rtl/pdu_shift.sv =====
module pdu_shift #(
    parameter int MAX_SHIFTS = pdu_pkg::MAX_SHIFTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    input  pdu_pkg::d_t     d   [3],
    input  pdu_pkg::coef_t  col [3][3],
    input  logic [pdu_pkg::WRAP_W-1:0] wrap,
    output logic           valid_out,
    output pdu_pkg::cu_t    u   [3]
);

    localparam int STEPS = 6 * MAX_SHIFTS;
    localparam int PR_W  = pdu_pkg::CU_W + pdu_pkg::COEF_W;
    localparam int DOT_W = PR_W + 2;
    localparam int CQ_W  = 2 * pdu_pkg::COEF_W + 2;
    localparam int CMP_W = DOT_W + 2;

    logic signed [2*pdu_pkg::COEF_W-1:0] cqp_reg [3][3];
    logic signed [CQ_W-1:0]              cq_reg  [3];

    pdu_pkg::cu_t u_chain [STEPS+1][3];
    logic         v_chain [STEPS+1];

    // squared cell column lengths, from static registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cqp_reg[k][i] <= col[k][i] * col[k][i];
            end
            cq_reg[k] <= CQ_W'(cqp_reg[k][0]) + CQ_W'(cqp_reg[k][1]) + CQ_W'(cqp_reg[k][2]);
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_in
        assign u_chain[0][i] = pdu_pkg::CU_W'(d[i]);
    end
    assign v_chain[0] = valid_in;

    // a failed step leaves u unchanged, so repeating it stands in for the early exit
    for (genvar n = 0; n < STEPS; n++)
    begin : g_step
        localparam int AX  = n / (2 * MAX_SHIFTS);
        localparam bit SUB = ((n / MAX_SHIFTS) % 2) == 1;

        logic signed [PR_W-1:0] pr_reg [3];
        pdu_pkg::cu_t           ua_reg [3];
        pdu_pkg::cu_t           ub_reg [3];
        logic                   va_reg;
        logic                   vb_reg;
        logic signed [DOT_W-1:0] dot;
        logic signed [CMP_W-1:0] gain;
        logic                    take;

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i] <= u_chain[n][i] * col[AX][i];
                ua_reg[i] <= u_chain[n][i];
            end
        end

        always_comb
        begin
            dot = DOT_W'(pr_reg[0]) + DOT_W'(pr_reg[1]) + DOT_W'(pr_reg[2]);
            if (SUB)
            begin
                gain = CMP_W'(cq_reg[AX]) - (CMP_W'(dot) <<< 1);
            end
            else
            begin
                gain = CMP_W'(cq_reg[AX]) + (CMP_W'(dot) <<< 1);
            end
            take = wrap[AX] && (gain < 0);
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!take)
                begin
                    ub_reg[i] <= ua_reg[i];
                end
                else if (SUB)
                begin
                    ub_reg[i] <= ua_reg[i] - pdu_pkg::CU_W'(col[AX][i]);
                end
                else
                begin
                    ub_reg[i] <= ua_reg[i] + pdu_pkg::CU_W'(col[AX][i]);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
            end
            else
            begin
                va_reg <= v_chain[n];
                vb_reg <= va_reg;
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            assign u_chain[n+1][i] = ub_reg[i];
        end
        assign v_chain[n+1] = vb_reg;
    end

    assign u         = u_chain[STEPS];
    assign valid_out = v_chain[STEPS];

endmodule

// ===== hw/rtl/pdu_isqrt.sv =====
module pdu_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    input  logic [pdu_pkg::SQ_W-1:0]    x,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        valid_out,
    output logic [pdu_pkg::ROOT_W-1:0]  root,
    output logic [SIDE_W-1:0]           side_out
);

    localparam int RW = pdu_pkg::ROOT_W;
    localparam int XW = pdu_pkg::SQ_W + 1;

    logic [XW-1:0]     rem_chain  [RW+1];
    logic [RW-1:0]     r_chain    [RW+1];
    logic [SIDE_W-1:0] side_chain [RW+1];
    logic              v_chain    [RW+1];

    assign rem_chain[0]  = XW'(x);
    assign r_chain[0]    = '0;
    assign side_chain[0] = side_in;
    assign v_chain[0]    = valid_in;

    // one root bit per stage, most significant first
    for (genvar j = 0; j < RW; j++)
    begin : g_bit
        localparam int B = RW - 1 - j;

        logic [XW-1:0]     trial;
        logic              ge;
        logic [XW-1:0]     rem_reg;
        logic [RW-1:0]     r_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              v_reg;

        always_comb
        begin
            trial = (XW'(r_chain[j]) << (B + 1)) | (XW'(1) << (2 * B));
            ge    = rem_chain[j] >= trial;
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= ge ? rem_chain[j] - trial : rem_chain[j];
            r_reg    <= ge ? (r_chain[j] | (RW'(1) << B)) : r_chain[j];
            side_reg <= side_chain[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else
            begin
                v_reg <= v_chain[j];
            end
        end

        assign rem_chain[j+1]  = rem_reg;
        assign r_chain[j+1]    = r_reg;
        assign side_chain[j+1] = side_reg;
        assign v_chain[j+1]    = v_reg;
    end

    assign root      = r_chain[RW];
    assign side_out  = side_chain[RW];
    assign valid_out = v_chain[RW];

endmodule

// ===== hw/rtl/periodic_displacement_unit.sv =====
// Minimum-image displacement under a triclinic cell. A new particle may be started every
// cycle (busy is always low); each result beat is flagged by done for one cycle, in start
// order. The receiver cannot hold a result off: it must take the beat in the cycle done is
// high. The latency is set by the cartesian shift search (two stages per trial shift, six
// trial slots per MAX_SHIFTS) and the 24-stage square root. Configuration writes take effect
// at once and must only be made with no beat in flight.
module periodic_displacement_unit #(
    parameter int MAX_SHIFTS = pdu_pkg::MAX_SHIFTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [pdu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pdu_pkg::CFG_W-1:0]     cfg_data,
    input  logic start,
    output logic busy,
    input  logic signed [pdu_pkg::POS_W-1:0] cur_x,
    input  logic signed [pdu_pkg::POS_W-1:0] cur_y,
    input  logic signed [pdu_pkg::POS_W-1:0] cur_z,
    input  logic signed [pdu_pkg::POS_W-1:0] ref_x,
    input  logic signed [pdu_pkg::POS_W-1:0] ref_y,
    input  logic signed [pdu_pkg::POS_W-1:0] ref_z,
    output logic done,
    output logic signed [pdu_pkg::POS_W-1:0] disp_x,
    output logic signed [pdu_pkg::POS_W-1:0] disp_y,
    output logic signed [pdu_pkg::POS_W-1:0] disp_z,
    output logic [pdu_pkg::MAG_W-1:0]        magnitude,
    output logic saturated
);

    localparam int PW     = pdu_pkg::POS_W;
    localparam int RD     = 12 * MAX_SHIFTS - 4;
    localparam int SIDE_W = 3 * PW + 2;
    localparam int SQP_W  = 2 * PW - 1;
    localparam logic signed [pdu_pkg::U_W-1:0] LIM = pdu_pkg::U_W'(1) <<< (PW - 1);
    localparam logic [pdu_pkg::ROOT_W-1:0] MAG_MAX = {1'b0, {pdu_pkg::MAG_W{1'b1}}};

    logic [pdu_pkg::CFG_W-1:0]  col_reg [3];
    logic [pdu_pkg::CFG_W-1:0]  inv_reg [3];
    logic [pdu_pkg::WRAP_W-1:0] wrap_reg;
    logic                       red_reg;

    pdu_pkg::coef_t col [3][3];
    pdu_pkg::coef_t inv [3][3];

    logic signed [PW-1:0] cur_v [3];
    logic signed [PW-1:0] ref_v [3];
    pdu_pkg::d_t          d_reg [3];
    logic                 v0_reg;

    pdu_pkg::u_t  u_r [3];
    pdu_pkg::u_t  rd_reg [RD][3];
    pdu_pkg::cu_t u_c [3];
    logic         v_c;

    pdu_pkg::u_t           u_sel [3];
    logic                  big;
    logic                  clip;
    logic signed [PW-1:0]  dclip [3];

    logic signed [PW-1:0]  disp1_reg [3];
    logic [SQP_W-1:0]      sq1_reg   [3];
    logic                  big1_reg;
    logic                  sat1_reg;
    logic                  v1_reg;

    logic [pdu_pkg::SQ_W-1:0] x2_reg;
    logic [SIDE_W-1:0]        side2_reg;
    logic                     v2_reg;

    logic                        vq;
    logic [pdu_pkg::ROOT_W-1:0]  root;
    logic [SIDE_W-1:0]           side_q;
    logic                        mag_clip;

    logic signed [PW-1:0]       disp_reg [3];
    logic [pdu_pkg::MAG_W-1:0]  mag_reg;
    logic                       sat_reg;
    logic                       done_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                col_reg[k] <= '0;
                inv_reg[k] <= '0;
            end
            wrap_reg <= '0;
            red_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (pdu_pkg::cfg_reg_t'(cfg_index))
                pdu_pkg::CFG_CELL_A:  col_reg[0] <= cfg_data;
                pdu_pkg::CFG_CELL_B:  col_reg[1] <= cfg_data;
                pdu_pkg::CFG_CELL_C:  col_reg[2] <= cfg_data;
                pdu_pkg::CFG_INV_X:   inv_reg[0] <= cfg_data;
                pdu_pkg::CFG_INV_Y:   inv_reg[1] <= cfg_data;
                pdu_pkg::CFG_INV_Z:   inv_reg[2] <= cfg_data;
                pdu_pkg::CFG_WRAP:    wrap_reg   <= cfg_data[pdu_pkg::WRAP_W-1:0];
                pdu_pkg::CFG_REDUCED: red_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_fld
        for (genvar i = 0; i < 3; i++)
        begin : g_cmp
            assign col[k][i] = col_reg[k][pdu_pkg::COEF_W*i +: pdu_pkg::COEF_W];
            assign inv[k][i] = inv_reg[k][pdu_pkg::COEF_W*i +: pdu_pkg::COEF_W];
        end
    end

    assign busy = 1'b0;

    assign cur_v[0] = cur_x;
    assign cur_v[1] = cur_y;
    assign cur_v[2] = cur_z;
    assign ref_v[0] = ref_x;
    assign ref_v[1] = ref_y;
    assign ref_v[2] = ref_z;

    // raw difference
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i] <= pdu_pkg::D_W'(cur_v[i]) - pdu_pkg::D_W'(ref_v[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
        end
    end

    pdu_reduced u_reduced (
        .clk  (clk),
        .d    (d_reg),
        .inv  (inv),
        .col  (col),
        .wrap (wrap_reg),
        .u    (u_r)
    );

    pdu_shift #(
        .MAX_SHIFTS (MAX_SHIFTS)
    ) u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v0_reg),
        .d         (d_reg),
        .col       (col),
        .wrap      (wrap_reg),
        .valid_out (v_c),
        .u         (u_c)
    );

    // align reduced path with the shift search
    always_ff @(posedge clk)
    begin
        rd_reg[0] <= u_r;
        for (int t = 1; t < RD; t++)
        begin
            rd_reg[t] <= rd_reg[t-1];
        end
    end

    // select, clip, square
    always_comb
    begin
        big  = 1'b0;
        clip = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            u_sel[i] = red_reg ? rd_reg[RD-1][i] : pdu_pkg::U_W'(u_c[i]);
            if (u_sel[i] >= LIM || u_sel[i] <= -LIM)
            begin
                big = 1'b1;
            end
            if (u_sel[i] >= LIM)
            begin
                dclip[i] = {1'b0, {(PW-1){1'b1}}};
                clip     = 1'b1;
            end
            else if (u_sel[i] < -LIM)
            begin
                dclip[i] = {1'b1, {(PW-1){1'b0}}};
                clip     = 1'b1;
            end
            else
            begin
                dclip[i] = u_sel[i][PW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            disp1_reg[i] <= dclip[i];
            sq1_reg[i]   <= SQP_W'(dclip[i] * dclip[i]);
        end
        big1_reg <= big;
        sat1_reg <= clip | big;
        x2_reg    <= pdu_pkg::SQ_W'(sq1_reg[0]) + pdu_pkg::SQ_W'(sq1_reg[1])
                   + pdu_pkg::SQ_W'(sq1_reg[2]);
        side2_reg <= {big1_reg, sat1_reg, disp1_reg[2], disp1_reg[1], disp1_reg[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v_c;
            v2_reg <= v1_reg;
        end
    end

    pdu_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v2_reg),
        .x         (x2_reg),
        .side_in   (side2_reg),
        .valid_out (vq),
        .root      (root),
        .side_out  (side_q)
    );

    assign mag_clip = side_q[SIDE_W-1] || (root > MAG_MAX);

    // result beat
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            disp_reg[i] <= side_q[PW*i +: PW];
        end
        mag_reg <= mag_clip ? MAG_MAX[pdu_pkg::MAG_W-1:0] : root[pdu_pkg::MAG_W-1:0];
        sat_reg <= side_q[SIDE_W-2] | mag_clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vq;
        end
    end

    assign done      = done_reg;
    assign disp_x    = disp_reg[0];
    assign disp_y    = disp_reg[1];
    assign disp_z    = disp_reg[2];
    assign magnitude = mag_reg;
    assign saturated = sat_reg;

endmodule
